// ----- rtl/fea_pkg.sv -----
package fea_pkg;

    // Default table size in entries (bytes in the store are twice this).
    localparam int DEF_ENTRY_COUNT = 4096;

    // Field widths of the stream payloads and configuration registers.
    localparam int KIND_W      = 2;
    localparam int CLUSTER_W   = 16;
    localparam int VALUE_W     = 16;
    localparam int MAXCL_W     = 12;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FAT12_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLUSTER = 1'b1;

    localparam logic [MAXCL_W-1:0] MAX_CLUSTER_RST = 12'hfff;

    // Kind codes.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'b00;

    // FAT12 special values: an entry whose bits 11..4 are all ones is widened.
    localparam logic [7:0] FAT12_SPECIAL_HI = 8'hff;
    localparam logic [3:0] FAT12_WIDEN      = 4'hf;

    // Decoded operation handed from the front to the back.
    typedef struct packed {
        logic do_get;
        logic do_set;
        logic invalid;
        logic fat12;
        logic odd;   // odd cluster: entry starts in the high nibble
        logic swap;  // byte address is odd: first byte sits in the odd bank
    } fea_op_t;

    // Status reported by the back.
    typedef struct packed {
        logic clearing;
    } fea_stat_t;

endpackage

// ----- rtl/fea_ram.sv -----
module fea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fea_queue.sv -----
module fea_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fea_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

endmodule

// ----- rtl/fea_front.sv -----
module fea_front #(
    parameter int ENTRY_COUNT = fea_pkg::DEF_ENTRY_COUNT
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fea_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               fat12_mode,
    input  logic [fea_pkg::MAXCL_W-1:0]        max_cluster,
    input  fea_pkg::fea_stat_t                 stat,
    input  logic                               q_full,
    output logic                               q_push,
    output fea_pkg::fea_op_t                   q_op,
    output logic [$clog2(ENTRY_COUNT)-1:0]     q_even_idx,
    output logic [$clog2(ENTRY_COUNT)-1:0]     q_odd_idx,
    output logic [fea_pkg::VALUE_W-1:0]        q_value
);

    import fea_pkg::*;

    localparam int IDX_W = $clog2(ENTRY_COUNT);

    logic [KIND_W-1:0]    kind;
    logic [CLUSTER_W-1:0] cluster;
    logic                 in_table;
    logic [IDX_W-1:0]     cl_idx;
    logic [IDX_W:0]       byte_addr;
    logic [IDX_W-1:0]     half_addr;

    assign kind    = s_tdata[1:0];
    assign cluster = s_tdata[17:2];
    assign q_value = s_tdata[33:18];

    assign in_table = ({1'b0, cluster} < 17'(ENTRY_COUNT));
    assign cl_idx   = cluster[IDX_W-1:0];

    // FAT12 entries start at cluster*1.5, FAT16 entries at cluster*2.
    assign byte_addr = fat12_mode ? ({1'b0, cl_idx} + {2'b00, cl_idx[IDX_W-1:1]})
                                  : {cl_idx, 1'b0};
    assign half_addr = byte_addr[IDX_W:1];

    // Even bytes live in one bank and odd bytes in the other, so the two
    // bytes of an entry are always in different banks.
    assign q_odd_idx  = half_addr;
    assign q_even_idx = half_addr + IDX_W'(byte_addr[0]);

    always_comb
    begin
        q_op.do_get  = kind[0];
        q_op.do_set  = kind[1];
        q_op.invalid = (kind == KIND_NONE) || (cluster < CLUSTER_W'(2))
                       || (cluster > {4'b0000, max_cluster}) || !in_table;
        q_op.fat12   = fat12_mode;
        q_op.odd     = cluster[0];
        q_op.swap    = byte_addr[0];
    end

    assign s_tready = !q_full && !stat.clearing;
    assign q_push   = s_tvalid && s_tready;

endmodule

// ----- rtl/fea_back.sv -----
module fea_back #(
    parameter int ENTRY_COUNT = fea_pkg::DEF_ENTRY_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  fea_pkg::fea_op_t                   q_op,
    input  logic [$clog2(ENTRY_COUNT)-1:0]     q_even_idx,
    input  logic [$clog2(ENTRY_COUNT)-1:0]     q_odd_idx,
    input  logic [fea_pkg::VALUE_W-1:0]        q_value,
    output logic                               q_pop,
    output logic                               ram_re,
    output logic                               ram_we,
    output logic [$clog2(ENTRY_COUNT)-1:0]     even_addr,
    output logic [$clog2(ENTRY_COUNT)-1:0]     odd_addr,
    output logic [7:0]                         even_wdata,
    output logic [7:0]                         odd_wdata,
    input  logic [7:0]                         even_rdata,
    input  logic [7:0]                         odd_rdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fea_pkg::M_TDATA_W-1:0]      m_tdata,
    output fea_pkg::fea_stat_t                 stat
);

    import fea_pkg::*;

    localparam int IDX_W = $clog2(ENTRY_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    fea_op_t            op_reg, op_next;
    logic [IDX_W-1:0]   even_idx_reg, even_idx_next;
    logic [IDX_W-1:0]   odd_idx_reg, odd_idx_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_old_reg, out_old_next;
    logic               out_status_reg, out_status_next;

    logic               slot_free;
    logic [7:0]         b0, b1, nb0, nb1;
    logic [15:0]        pair, shifted;
    logic [11:0]        entry12;
    logic [VALUE_W-1:0] old_value;

    // Bytes at the entry address and the one after it, whichever bank.
    assign b0 = op_reg.swap ? odd_rdata : even_rdata;
    assign b1 = op_reg.swap ? even_rdata : odd_rdata;

    assign pair    = {b1, b0};
    assign shifted = op_reg.odd ? (pair >> 4) : pair;
    assign entry12 = shifted[11:0];

    always_comb
    begin
        if (op_reg.fat12)
        begin
            old_value = (entry12[11:4] == FAT12_SPECIAL_HI) ? {FAT12_WIDEN, entry12}
                                                            : {4'h0, entry12};
            if (op_reg.odd)
            begin
                nb0 = {value_reg[3:0], b0[3:0]};
                nb1 = value_reg[11:4];
            end
            else
            begin
                nb0 = value_reg[7:0];
                nb1 = {b1[7:4], value_reg[11:8]};
            end
        end
        else
        begin
            old_value = pair;
            nb0       = value_reg[7:0];
            nb1       = value_reg[15:8];
        end
    end

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        even_idx_next   = even_idx_reg;
        odd_idx_next    = odd_idx_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_old_next    = out_old_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        even_addr       = q_even_idx;
        odd_addr        = q_odd_idx;
        even_wdata      = op_reg.swap ? nb1 : nb0;
        odd_wdata       = op_reg.swap ? nb0 : nb1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                even_addr  = clr_cnt_reg;
                odd_addr   = clr_cnt_reg;
                even_wdata = '0;
                odd_wdata  = '0;
                ram_we     = 1'b1;
                if (clr_cnt_reg == IDX_W'(ENTRY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_op.invalid)
                    begin
                        if (slot_free)
                        begin
                            q_pop           = 1'b1;
                            out_valid_next  = 1'b1;
                            out_old_next    = '0;
                            out_status_next = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop         = 1'b1;
                        ram_re        = 1'b1;
                        op_next       = q_op;
                        even_idx_next = q_even_idx;
                        odd_idx_next  = q_odd_idx;
                        value_next    = q_value;
                        state_next    = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                even_addr = even_idx_reg;
                odd_addr  = odd_idx_reg;
                if (slot_free)
                begin
                    ram_we          = op_reg.do_set;
                    out_valid_next  = 1'b1;
                    out_old_next    = op_reg.do_get ? old_value : '0;
                    out_status_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        even_idx_reg   <= even_idx_next;
        odd_idx_reg    <= odd_idx_next;
        value_reg      <= value_next;
        out_old_reg    <= out_old_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {7'b0000000, out_status_reg, out_old_reg};
    assign stat.clearing = (state_reg == ST_CLEAR);

endmodule

// ----- rtl/fat_entry_access.sv -----
// A valid get/set item leaves the queue for a read state on the byte banks,
// then a write state that waits for a free result slot and loads the result
// register; the back takes no new item until both are done. Invalid items
// load the result from the queue head, one per cycle while m_tready is high.
// Reset: asynchronous, active low. Afterwards the table is cleared to zero,
// all ENTRY_COUNT rows, one row of both banks per cycle, with s_tready held low.
module fat_entry_access #(
    parameter int ENTRY_COUNT = fea_pkg::DEF_ENTRY_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [fea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fea_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: kind[1:0], cluster[17:2], new_value[33:18], zero[39:34]
    input  logic [fea_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: old_value[15:0], status[16], zero[23:17]
    output logic [fea_pkg::M_TDATA_W-1:0]   m_tdata
);

    import fea_pkg::*;

    localparam int IDX_W  = $clog2(ENTRY_COUNT);
    localparam int OP_W   = $bits(fea_op_t);
    localparam int Q_W    = OP_W + 2 * IDX_W + VALUE_W;

    // Configuration registers. Software must write them only while idle, so
    // items in flight see a stable mode and limit; the block does not enforce it.
    logic               fat12_mode_reg, fat12_mode_next;
    logic [MAXCL_W-1:0] max_cluster_reg, max_cluster_next;

    always_comb
    begin
        fat12_mode_next  = fat12_mode_reg;
        max_cluster_next = max_cluster_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAT12_MODE:  fat12_mode_next  = cfg_data[0];
                CFG_MAX_CLUSTER: max_cluster_next = cfg_data[MAXCL_W-1:0];
                default:         fat12_mode_next  = fat12_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat12_mode_reg  <= 1'b0;
            max_cluster_reg <= MAX_CLUSTER_RST;
        end
        else
        begin
            fat12_mode_reg  <= fat12_mode_next;
            max_cluster_reg <= max_cluster_next;
        end
    end

    // The front decodes each request: it checks the kind and the cluster range
    // and turns the cluster into a row index for each byte bank.
    fea_stat_t          back_stat;
    logic               q_full;
    logic               q_push;
    fea_op_t            f_op;
    logic [IDX_W-1:0]   f_even_idx;
    logic [IDX_W-1:0]   f_odd_idx;
    logic [VALUE_W-1:0] f_value;

    fea_front #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .fat12_mode  (fat12_mode_reg),
        .max_cluster (max_cluster_reg),
        .stat        (back_stat),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (f_op),
        .q_even_idx  (f_even_idx),
        .q_odd_idx   (f_odd_idx),
        .q_value     (f_value)
    );

    // A short queue lets the front keep taking transactions while the back
    // works on a read-modify-write or waits on a stalled result.
    logic [Q_W-1:0]     q_in;
    logic [Q_W-1:0]     q_head;
    logic               q_valid;
    logic               q_pop;
    fea_op_t            b_op;
    logic [IDX_W-1:0]   b_even_idx;
    logic [IDX_W-1:0]   b_odd_idx;
    logic [VALUE_W-1:0] b_value;

    assign q_in = {f_op, f_even_idx, f_odd_idx, f_value};

    fea_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign {b_op, b_even_idx, b_odd_idx, b_value} = q_head;

    // The back reads both bytes of the entry together; once the result slot is
    // free, it writes the merged bytes of a set and loads the result register.
    logic             ram_re;
    logic             ram_we;
    logic [IDX_W-1:0] even_addr;
    logic [IDX_W-1:0] odd_addr;
    logic [7:0]       even_wdata;
    logic [7:0]       odd_wdata;
    logic [7:0]       even_rdata;
    logic [7:0]       odd_rdata;

    fea_back #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (b_op),
        .q_even_idx (b_even_idx),
        .q_odd_idx  (b_odd_idx),
        .q_value    (b_value),
        .q_pop      (q_pop),
        .ram_re     (ram_re),
        .ram_we     (ram_we),
        .even_addr  (even_addr),
        .odd_addr   (odd_addr),
        .even_wdata (even_wdata),
        .odd_wdata  (odd_wdata),
        .even_rdata (even_rdata),
        .odd_rdata  (odd_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .stat       (back_stat)
    );

    // The byte store is split into an even-address bank and an odd-address
    // bank, each ENTRY_COUNT bytes deep.
    fea_ram #(
        .WIDTH (8),
        .DEPTH (ENTRY_COUNT)
    ) u_even_bank (
        .clk   (clk),
        .we    (ram_we),
        .waddr (even_addr),
        .wdata (even_wdata),
        .re    (ram_re),
        .raddr (even_addr),
        .rdata (even_rdata)
    );

    fea_ram #(
        .WIDTH (8),
        .DEPTH (ENTRY_COUNT)
    ) u_odd_bank (
        .clk   (clk),
        .we    (ram_we),
        .waddr (odd_addr),
        .wdata (odd_wdata),
        .re    (ram_re),
        .raddr (odd_addr),
        .rdata (odd_rdata)
    );

    // No request is taken while the table is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> !s_tready)
    else $error("request accepted during table clear");

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
    else $error("queue overflow");

    // An invalid result always carries a zero entry value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == '0))
    else $error("invalid result with nonzero old value");

    // The banks are never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
    else $error("bank read and write collide");

endmodule
